@@ design/ssst_pkg.sv @@
// sorted segment set table: shared package
// field widths, command and status codes, controller/datapath structs
// no dependencies
`timescale 1ns / 1ps

package ssst_pkg;

  // fixed field widths of the channels
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned NODE_W     = 16;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CNT_OUT_W  = 6;

  // command codes
  localparam logic [CMD_W-1:0] CMD_MERGE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUB   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

  // write data / address select
  typedef enum logic [1:0] {
    WS_KEY,
    WS_CARRY,
    WS_DOWN
  } wsel_e;

  // controller to datapath
  typedef struct packed {
    logic                load;
    logic                ptr_inc;
    logic                wr_en;
    wsel_e               wr_sel;
    logic                carry_ld;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                res_ld;
    logic [STATUS_W-1:0] res_status;
    logic                res_rd;
    logic                out_ld;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             at_end;
    logic             hit;
    logic             stop;
    logic             full;
    logic             last;
    logic             idx_ok;
    logic             out_free;
  } stat_t;

endpackage

@@ design/ssst_if.sv @@
// sorted segment set table: channel interfaces
// depends on ssst_pkg for field widths
`timescale 1ns / 1ps

// input channel: one command item
interface ssst_in_if;
  logic                         valid;
  logic                         ready;
  logic [ssst_pkg::CMD_W-1:0]   command;
  logic [ssst_pkg::NODE_W-1:0]  node_id;
  logic                         seg_kind;
  logic [ssst_pkg::IDX_W-1:0]   read_index;

  modport source (output valid, command, node_id, seg_kind, read_index, input ready);
  modport sink   (input valid, command, node_id, seg_kind, read_index, output ready);
endinterface

// output channel: one result item
interface ssst_out_if;
  logic                           valid;
  logic                           ready;
  logic [ssst_pkg::STATUS_W-1:0]  status;
  logic [ssst_pkg::NODE_W-1:0]    out_node_id;
  logic                           out_seg_kind;
  logic [ssst_pkg::CNT_OUT_W-1:0] entry_count;

  modport source (output valid, status, out_node_id, out_seg_kind, entry_count, input ready);
  modport sink   (input valid, status, out_node_id, out_seg_kind, entry_count, output ready);
endinterface

@@ design/ssst_ram.sv @@
// sorted segment set table: generic single write, single read RAM
// registered read data, no reset; no dependencies
`timescale 1ns / 1ps

module ssst_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ design/ssst_ctrl.sv @@
// sorted segment set table: controller state machine
// sequences scan, shift up, shift down, read and result hand-off; uses ssst_pkg
`timescale 1ns / 1ps

module ssst_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [ssst_pkg::CMD_W-1:0] in_cmd_i,
  output logic                       in_ready_o,
  input  ssst_pkg::stat_t            stat_i,
  output ssst_pkg::ctrl_t            ctrl_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_UP   = 3'd2;
  localparam logic [2:0] S_DN   = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_d       = state_q;
    ctrl_o        = '0;
    ctrl_o.wr_sel = ssst_pkg::WS_KEY;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          case (in_cmd_i)
            ssst_pkg::CMD_MERGE,
            ssst_pkg::CMD_SUB:  state_d = S_SCAN;
            ssst_pkg::CMD_READ: state_d = S_READ;
            default: begin
              ctrl_o.res_ld     = 1'b1;
              ctrl_o.res_status = ssst_pkg::ST_DONE;
              state_d           = S_FIN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!stat_i.stop) begin
          ctrl_o.ptr_inc = 1'b1;
        end else if (stat_i.cmd == ssst_pkg::CMD_MERGE) begin
          if (stat_i.hit) begin
            ctrl_o.res_ld     = 1'b1;
            ctrl_o.res_status = ssst_pkg::ST_PRESENT;
            state_d           = S_FIN;
          end else if (stat_i.full) begin
            ctrl_o.res_ld     = 1'b1;
            ctrl_o.res_status = ssst_pkg::ST_FULL;
            state_d           = S_FIN;
          end else begin
            // place the key here and carry the displaced entry upward
            ctrl_o.wr_en    = 1'b1;
            ctrl_o.wr_sel   = ssst_pkg::WS_KEY;
            ctrl_o.carry_ld = 1'b1;
            if (stat_i.at_end) begin
              ctrl_o.cnt_inc    = 1'b1;
              ctrl_o.res_ld     = 1'b1;
              ctrl_o.res_status = ssst_pkg::ST_DONE;
              state_d           = S_FIN;
            end else begin
              ctrl_o.ptr_inc = 1'b1;
              state_d        = S_UP;
            end
          end
        end else begin
          if (!stat_i.hit) begin
            ctrl_o.res_ld     = 1'b1;
            ctrl_o.res_status = ssst_pkg::ST_ABSENT;
            state_d           = S_FIN;
          end else if (stat_i.last) begin
            ctrl_o.cnt_dec    = 1'b1;
            ctrl_o.res_ld     = 1'b1;
            ctrl_o.res_status = ssst_pkg::ST_DONE;
            state_d           = S_FIN;
          end else begin
            ctrl_o.ptr_inc = 1'b1;
            state_d        = S_DN;
          end
        end
      end
      S_UP: begin
        ctrl_o.wr_en    = 1'b1;
        ctrl_o.wr_sel   = ssst_pkg::WS_CARRY;
        ctrl_o.carry_ld = 1'b1;
        if (stat_i.at_end) begin
          ctrl_o.cnt_inc    = 1'b1;
          ctrl_o.res_ld     = 1'b1;
          ctrl_o.res_status = ssst_pkg::ST_DONE;
          state_d           = S_FIN;
        end else begin
          ctrl_o.ptr_inc = 1'b1;
        end
      end
      S_DN: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.wr_sel = ssst_pkg::WS_DOWN;
        if (stat_i.last) begin
          ctrl_o.cnt_dec    = 1'b1;
          ctrl_o.res_ld     = 1'b1;
          ctrl_o.res_status = ssst_pkg::ST_DONE;
          state_d           = S_FIN;
        end else begin
          ctrl_o.ptr_inc = 1'b1;
        end
      end
      S_READ: begin
        ctrl_o.res_ld     = 1'b1;
        ctrl_o.res_rd     = stat_i.idx_ok;
        ctrl_o.res_status = stat_i.idx_ok ? ssst_pkg::ST_DONE : ssst_pkg::ST_RANGE;
        state_d           = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          ctrl_o.out_ld = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/ssst_dp.sv @@
// sorted segment set table: datapath
// key store RAM, scan pointer, count, carry, result and output registers
// uses ssst_pkg and ssst_ram
`timescale 1ns / 1ps

module ssst_dp #(
  parameter int unsigned SET_DEPTH = 32,
  parameter int unsigned NODE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ssst_pkg::ctrl_t                ctrl_i,
  output ssst_pkg::stat_t                stat_o,
  input  logic [ssst_pkg::CMD_W-1:0]     in_cmd_i,
  input  logic [ssst_pkg::NODE_W-1:0]    in_node_i,
  input  logic                           in_kind_i,
  input  logic [ssst_pkg::IDX_W-1:0]     in_idx_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [ssst_pkg::STATUS_W-1:0]  out_status_o,
  output logic [ssst_pkg::NODE_W-1:0]    out_node_o,
  output logic                           out_kind_o,
  output logic [ssst_pkg::CNT_OUT_W-1:0] out_count_o
);

  localparam int unsigned KW  = NODE_BITS + 1;
  localparam int unsigned AW  = $clog2(SET_DEPTH);
  localparam int unsigned CW  = $clog2(SET_DEPTH + 1);
  localparam int unsigned IW  = (CW > ssst_pkg::IDX_W) ? CW : ssst_pkg::IDX_W;
  localparam int unsigned OW  = ssst_pkg::NODE_W;
  localparam int unsigned XW  = ssst_pkg::IDX_W;
  localparam int unsigned NW  = ssst_pkg::CNT_OUT_W;

  logic [ssst_pkg::CMD_W-1:0]    cmd_q;
  logic [KW-1:0]                 key_q;
  logic [ssst_pkg::IDX_W-1:0]    idx_q;
  logic [KW-1:0]                 carry_q;
  logic [CW-1:0]                 ptr_q, ptr_d, ptr_nx;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [ssst_pkg::STATUS_W-1:0] res_status_q;
  logic [OW-1:0]                 res_node_q;
  logic                          res_kind_q;
  logic                          out_valid_q;

  logic [NODE_BITS-1:0] node_in;
  logic [OW-1:0]        rd_node;
  logic [AW-1:0]        idx_addr;
  logic [AW-1:0]        raddr, waddr;
  logic [KW-1:0]        wdata, rdata;
  logic [NW-1:0]        cnt_out;

  // width adaptation between fixed fields and parameter widths
  generate
    if (NODE_BITS <= OW) begin : g_node_narrow
      assign node_in = in_node_i[NODE_BITS-1:0];
    end else begin : g_node_wide
      assign node_in = {{(NODE_BITS - OW){1'b0}}, in_node_i};
    end
    if (NODE_BITS >= OW) begin : g_out_trunc
      assign rd_node = rdata[OW:1];
    end else begin : g_out_ext
      assign rd_node = {{(OW - NODE_BITS){1'b0}}, rdata[NODE_BITS:1]};
    end
    if (AW >= XW) begin : g_idx_ext
      assign idx_addr = {{(AW - XW){1'b0}}, in_idx_i};
    end else begin : g_idx_trunc
      assign idx_addr = in_idx_i[AW-1:0];
    end
    if (CW >= NW) begin : g_cnt_trunc
      assign cnt_out = cnt_q[NW-1:0];
    end else begin : g_cnt_ext
      assign cnt_out = {{(NW - CW){1'b0}}, cnt_q};
    end
  endgenerate

  assign ptr_nx = ptr_q + CW'(1);

  // read address runs one ahead of the pointer
  always_comb begin
    if (ctrl_i.load) begin
      raddr = (in_cmd_i == ssst_pkg::CMD_READ) ? idx_addr : '0;
    end else begin
      raddr = ptr_nx[AW-1:0];
    end
  end

  // write address and data
  always_comb begin
    case (ctrl_i.wr_sel)
      ssst_pkg::WS_KEY: begin
        waddr = ptr_q[AW-1:0];
        wdata = key_q;
      end
      ssst_pkg::WS_CARRY: begin
        waddr = ptr_q[AW-1:0];
        wdata = carry_q;
      end
      ssst_pkg::WS_DOWN: begin
        waddr = ptr_q[AW-1:0] - AW'(1);
        wdata = rdata;
      end
      default: begin
        waddr = ptr_q[AW-1:0];
        wdata = key_q;
      end
    endcase
  end

  ssst_ram #(
    .WIDTH (KW),
    .DEPTH (SET_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // status toward the controller
  always_comb begin
    stat_o.cmd      = cmd_q;
    stat_o.at_end   = (ptr_q == cnt_q);
    stat_o.hit      = (ptr_q != cnt_q) && (rdata == key_q);
    stat_o.stop     = (ptr_q == cnt_q) || (rdata >= key_q);
    stat_o.full     = (cnt_q == CW'(SET_DEPTH));
    stat_o.last     = (ptr_nx == cnt_q);
    stat_o.idx_ok   = (IW'(idx_q) < IW'(cnt_q));
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  // pointer and count
  always_comb begin
    ptr_d = ptr_q;
    if (ctrl_i.load) begin
      ptr_d = '0;
    end else if (ctrl_i.ptr_inc) begin
      ptr_d = ptr_nx;
    end
    cnt_d = cnt_q;
    if (ctrl_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (ctrl_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
      if (ctrl_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item latch, carry, result and output payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= in_cmd_i;
      key_q <= {node_in, in_kind_i};
      idx_q <= in_idx_i;
    end
    if (ctrl_i.carry_ld) begin
      carry_q <= rdata;
    end
    if (ctrl_i.res_ld) begin
      res_status_q <= ctrl_i.res_status;
      res_node_q   <= ctrl_i.res_rd ? rd_node : '0;
      res_kind_q   <= ctrl_i.res_rd ? rdata[0] : 1'b0;
    end
    // count is captured with the result so a later item cannot change it
    if (ctrl_i.out_ld) begin
      out_status_o <= res_status_q;
      out_node_o   <= res_node_q;
      out_kind_o   <= res_kind_q;
      out_count_o  <= cnt_out;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ design/sorted_segment_set_table.sv @@
// sorted segment set table: top level
// joins ssst_ctrl and ssst_dp; uses ssst_pkg and the ssst_if channels
//
// Holds up to SET_DEPTH distinct keys (node number, kind bit) in ascending
// order. Each item on in_i carries a command: merge inserts the key if it is
// absent, subtract removes it if present, read returns the entry at a sorted
// position. Every item gives exactly one result item on out_o with a status
// and the entry count after the operation.
// One item is in work at a time; in_i.ready is high while the block idles.
// Merge and subtract scan the store through one RAM read port and shift the
// tail one entry a cycle. The result waits in an output register; the next
// item is accepted while it waits, and a stalled receiver holds the block
// only once that next result is ready to be handed over.
// Reset empties the set at once (count to zero); no clearing pass is needed
// since entries beyond the count are never read.
`timescale 1ns / 1ps

module sorted_segment_set_table #(
  parameter int unsigned SET_DEPTH = 32,
  parameter int unsigned NODE_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssst_in_if.sink   in_i,
  ssst_out_if.source out_o
);

  ssst_pkg::ctrl_t ctrl;
  ssst_pkg::stat_t stat;

  // controller
  ssst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.command),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // datapath
  ssst_dp #(
    .SET_DEPTH (SET_DEPTH),
    .NODE_BITS (NODE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .in_cmd_i     (in_i.command),
    .in_node_i    (in_i.node_id),
    .in_kind_i    (in_i.seg_kind),
    .in_idx_i     (in_i.read_index),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_status_o (out_o.status),
    .out_node_o   (out_o.out_node_id),
    .out_kind_o   (out_o.out_seg_kind),
    .out_count_o  (out_o.entry_count)
  );

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("item accepted while another is in work");

  // count never grows past the depth and never moves both ways
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.cnt_inc |-> !stat.full && !ctrl.cnt_dec)
    else $error("count step while store full or conflicting");

  // the store is written only while an item is in work
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.wr_en |-> !in_i.ready)
    else $error("store written while idle");

  // only a successful read carries a key
  a_zero_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status != ssst_pkg::ST_DONE)
      |-> (out_o.out_node_id == '0) && !out_o.out_seg_kind)
    else $error("key shown on a result that is not a read");

endmodule
